### hdl/wtm_pkg.sv
package wtm_pkg;

	localparam int TRACK_COUNT = 4;
	localparam int SAMPLE_W    = 16;
	localparam int VOL_W       = 8;
	localparam int LOG_T       = $clog2(TRACK_COUNT);
	localparam int TRK_IDX_W   = (TRACK_COUNT > 1) ? LOG_T : 1;
	localparam int CFG_IDX_W   = TRK_IDX_W + 1;
	localparam int PROD_W      = SAMPLE_W + VOL_W;
	localparam int SUM_W       = PROD_W + LOG_T;
	localparam int MAG_W       = SUM_W - 1;
	localparam int WSUM_W      = VOL_W + LOG_T;

	localparam logic [VOL_W-1:0] VOL_RESET = VOL_W'(1);

	typedef struct packed {
		logic [MAG_W-1:0]  dvd;
		logic [WSUM_W-1:0] rem;
		logic [WSUM_W-1:0] dvs;
		logic              neg;
		logic              zero;
	} wtm_div_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] mixed;
		logic                       no_weight;
	} wtm_res_t;

endpackage

### hdl/wtm_if.sv
interface wtm_in_if;
	import wtm_pkg::*;

	logic                                  valid;
	logic                                  ready;
	logic [TRACK_COUNT-1:0][SAMPLE_W-1:0] sample;
	logic [3:0]                            active_mask;

	modport source (output valid, output sample, output active_mask, input ready);
	modport sink   (input valid, input sample, input active_mask, output ready);
endinterface

interface wtm_out_if;
	import wtm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mixed_sample;
	logic                       no_weight;

	modport source (output valid, output mixed_sample, output no_weight, input ready);
	modport sink   (input valid, input mixed_sample, input no_weight, output ready);
endinterface

### hdl/wtm_lane.sv
module wtm_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic [wtm_pkg::SAMPLE_W-1:0]        sample,
	input  logic [wtm_pkg::VOL_W-1:0]           vol,
	input  logic                                act,
	output logic signed [wtm_pkg::PROD_W-1:0]   prod_s1,
	output logic [wtm_pkg::VOL_W-1:0]           wgt_s1
);
	import wtm_pkg::*;

	logic signed [PROD_W:0] prod_full;

	assign prod_full = $signed(sample) * $signed({1'b0, vol});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= act ? $signed(prod_full[PROD_W-1:0]) : '0;
			wgt_s1  <= act ? vol : '0;
		end
	end

endmodule

### hdl/wtm_merge.sv
module wtm_merge (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [wtm_pkg::PROD_W-1:0] prod [wtm_pkg::TRACK_COUNT],
	input  logic [wtm_pkg::VOL_W-1:0]         wgt [wtm_pkg::TRACK_COUNT],
	output wtm_pkg::wtm_div_t                 div_s3
);
	import wtm_pkg::*;

	logic signed [SUM_W-1:0] psum;
	logic [WSUM_W-1:0]       wsum;
	logic signed [SUM_W-1:0] psum_s2;
	logic [WSUM_W-1:0]       wsum_s2;
	logic [SUM_W-1:0]        mag;

	// adder across lanes
	always_comb begin
		psum = '0;
		wsum = '0;
		for (int k = 0; k < TRACK_COUNT; k++) begin
			psum = psum + SUM_W'(prod[k]);
			wsum = wsum + WSUM_W'(wgt[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psum_s2 <= psum;
			wsum_s2 <= wsum;
		end
	end

	assign mag = psum_s2[SUM_W-1] ? SUM_W'(-psum_s2) : SUM_W'(psum_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			div_s3.dvd  <= mag[MAG_W-1:0];
			div_s3.rem  <= '0;
			div_s3.dvs  <= wsum_s2;
			div_s3.neg  <= psum_s2[SUM_W-1];
			div_s3.zero <= (wsum_s2 == '0);
		end
	end

endmodule

### hdl/wtm_div_step.sv
module wtm_div_step (
	input  logic              clk,
	input  logic              en,
	input  wtm_pkg::wtm_div_t d,
	output wtm_pkg::wtm_div_t q
);
	import wtm_pkg::*;

	logic [WSUM_W:0] trial;
	logic [WSUM_W:0] diff;
	logic            ge;

	// one restoring step: quotient bit shifts in at the bottom of dvd
	assign trial = {d.rem, d.dvd[MAG_W-1]};
	assign diff  = trial - {1'b0, d.dvs};
	assign ge    = (trial >= {1'b0, d.dvs});

	always_ff @(posedge clk) begin
		if (en) begin
			q.dvd  <= {d.dvd[MAG_W-2:0], ge};
			q.rem  <= ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
			q.dvs  <= d.dvs;
			q.neg  <= d.neg;
			q.zero <= d.zero;
		end
	end

endmodule

### hdl/weighted_track_mixer_unit.sv
// Weighted track mixer. Each item carries one sample per track and an activity
// mask; the result is sum(vol_k * sample_k) / sum(vol_k) over the active tracks,
// truncated toward zero, or 0 with no_weight set when the active weights sum to
// zero. One item is accepted every clock cycle while input ready is high. Each
// accepted item passes through the per-track multiplier registers, the lane
// adder and the sign and magnitude split registers, the pipelined restoring
// divider (MAG_W = 25 quotient bits with four tracks), the output sign register
// and the output register. Input ready drops only when both the output
// register and its skid entry hold results. Weights vol_k are written through
// cfg_we/cfg_idx/cfg_data, reset to 1, and should only be changed while no item
// is in flight.
module weighted_track_mixer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wtm_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [wtm_pkg::VOL_W-1:0]     cfg_data,
	wtm_in_if.sink                        in_ch,
	wtm_out_if.source                     out_ch
);
	import wtm_pkg::*;

	localparam int STG_N = MAG_W + 4;

	logic [VOL_W-1:0]         vol_q [TRACK_COUNT];
	logic [STG_N-1:0]         vld_q;
	logic                     adv;
	logic signed [PROD_W-1:0] prod_s1 [TRACK_COUNT];
	logic [VOL_W-1:0]         wgt_s1 [TRACK_COUNT];
	wtm_div_t                 div_s [MAG_W+1];
	logic [SAMPLE_W-1:0]      quo;
	wtm_res_t                 res_s;
	logic                     arr;
	logic                     take;
	logic                     out_v_q;
	wtm_res_t                 out_d_q;
	logic                     skid_v_q;
	wtm_res_t                 skid_d_q;

	// weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TRACK_COUNT; k++) begin
				vol_q[k] <= VOL_RESET;
			end
		end else if (cfg_we && (cfg_idx < CFG_IDX_W'(TRACK_COUNT))) begin
			vol_q[cfg_idx[TRK_IDX_W-1:0]] <= cfg_data;
		end
	end

	assign adv         = !skid_v_q;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[STG_N-2:0], in_ch.valid};
		end
	end

	for (genvar k = 0; k < TRACK_COUNT; k++) begin : g_lane
		wtm_lane u_lane (
			.clk     (clk),
			.en      (adv),
			.sample  (in_ch.sample[k]),
			.vol     (vol_q[k]),
			.act     (in_ch.active_mask[k]),
			.prod_s1 (prod_s1[k]),
			.wgt_s1  (wgt_s1[k])
		);
	end

	wtm_merge u_merge (
		.clk    (clk),
		.en     (adv),
		.prod   (prod_s1),
		.wgt    (wgt_s1),
		.div_s3 (div_s[0])
	);

	for (genvar i = 0; i < MAG_W; i++) begin : g_div
		wtm_div_step u_step (
			.clk (clk),
			.en  (adv),
			.d   (div_s[i]),
			.q   (div_s[i+1])
		);
	end

	// sign restore
	assign quo = div_s[MAG_W].dvd[SAMPLE_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s.no_weight <= div_s[MAG_W].zero;
			if (div_s[MAG_W].zero) begin
				res_s.mixed <= '0;
			end else if (div_s[MAG_W].neg) begin
				res_s.mixed <= $signed(SAMPLE_W'(-quo));
			end else begin
				res_s.mixed <= $signed(quo);
			end
		end
	end

	// output register with skid entry
	assign arr  = adv && vld_q[STG_N-1];
	assign take = out_v_q && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= arr;
			end
		end else if (arr) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			out_d_q <= skid_v_q ? skid_d_q : res_s;
		end else if (arr) begin
			skid_d_q <= res_s;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.mixed_sample = out_d_q.mixed;
	assign out_ch.no_weight    = out_d_q.no_weight;

endmodule

### verif/weighted_track_mixer_unit_tb.sv
module weighted_track_mixer_unit_tb;
	import wtm_pkg::*;

	localparam int DIR_N        = 21;
	localparam int DIR_REWEIGHT = 14;
	localparam int PHASES       = 10;
	localparam int PHASE_SLOTS  = 113;
	localparam int BURST_SLOTS  = 120;
	localparam int HOLD_CYCLES  = 200;
	localparam int TAIL_CYCLES  = MAG_W + 15;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [TRACK_COUNT-1:0][SAMPLE_W-1:0] smp;
		logic [3:0]                           mask;
	} slot_t;

	typedef struct packed {
		slot_t    s;
		logic     typed;
		wtm_res_t want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_idx;
	logic [VOL_W-1:0]       cfg_data;

	wtm_in_if  in_ch ();
	wtm_out_if out_ch ();

	weighted_track_mixer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	logic [VOL_W-1:0] track_vol [TRACK_COUNT];
	wtm_res_t         mix_expected_q [$];
	logic             slot_typed;
	wtm_res_t         slot_want;
	bit               hold_req;
	bit               no_idle;
	int               mix_errors;
	int               slots_sent;
	int               mixes_seen;
	int               silent_mixes;
	int               weight_sets;
	int               cycles;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic wtm_res_t weighted_mix(input logic [TRACK_COUNT-1:0][SAMPLE_W-1:0] smp,
			input logic [3:0] mask);
		longint   acc;
		longint   wsum;
		wtm_res_t r;
		int       k;
		acc  = 0;
		wsum = 0;
		for (k = 0; k < TRACK_COUNT; k++) begin
			if (mask[k]) begin
				wsum += longint'(track_vol[k]);
				acc  += longint'(track_vol[k]) * longint'($signed(smp[k]));
			end
		end
		if (wsum == 0) begin
			r.mixed     = '0;
			r.no_weight = 1'b1;
		end else begin
			r.mixed     = SAMPLE_W'(acc / wsum);
			r.no_weight = 1'b0;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// samples listed track 3 first
	function automatic dir_row_t dir_row(input int i);
		case (i)
			0:  return {64'h7FFF_7FFF_7FFF_7FFF, 4'h0, 1'b1, 16'h0000, 1'b1};
			1:  return {64'h7FFF_7FFF_7FFF_7FFF, 4'hF, 1'b1, 16'h7FFF, 1'b0};
			2:  return {64'h8000_8000_8000_8000, 4'hF, 1'b1, 16'h8000, 1'b0};
			3:  return {64'h0000_0000_0000_FFFF, 4'h1, 1'b1, 16'hFFFF, 1'b0};
			4:  return {64'h1234_5678_0000_FFFF, 4'h3, 1'b1, 16'h0000, 1'b0};
			5:  return {64'h0000_0000_0000_0001, 4'h3, 1'b1, 16'h0000, 1'b0};
			6:  return {64'h0000_0000_0000_FFFD, 4'h3, 1'b1, 16'hFFFF, 1'b0};
			7:  return {64'h0000_0000_8000_7FFF, 4'h3, 1'b1, 16'h0000, 1'b0};
			8:  return {64'h3039_8000_7FFF_8000, 4'h8, 1'b1, 16'h3039, 1'b0};
			9:  return {64'h7FFF_8000_7FFF_7FFF, 4'h4, 1'b1, 16'h8000, 1'b0};
			10: return {64'h0190_012C_00C8_0064, 4'hF, 1'b1, 16'h00FA, 1'b0};
			11: return {64'hAAAA_5555_AAAA_5555, 4'h5, 1'b1, 16'h5555, 1'b0};
			12: return {64'hAAAA_5555_AAAA_5555, 4'hA, 1'b1, 16'hAAAA, 1'b0};
			13: return {64'h1357_9BDF_2468_ACE0, 4'hE, 1'b0, 16'h0000, 1'b0};
			// weights from here: track 0 = 0, 1 = 255, 2 = 1, 3 = 0
			14: return {64'h7FFF_8000_8000_7FFF, 4'h9, 1'b1, 16'h0000, 1'b1};
			15: return {64'h7FFF_7FFF_7FFF_7FFF, 4'hF, 1'b1, 16'h7FFF, 1'b0};
			16: return {64'h8000_8000_8000_8000, 4'hF, 1'b1, 16'h8000, 1'b0};
			17: return {64'h0000_7FFF_8000_0000, 4'h6, 1'b0, 16'h0000, 1'b0};
			18: return {64'h0000_0000_0000_0005, 4'h1, 1'b1, 16'h0000, 1'b1};
			19: return {64'h4321_FEDC_0BAD_7FFF, 4'h7, 1'b0, 16'h0000, 1'b0};
			default: return {64'h0000_0000_8000_0000, 4'h2, 1'b1, 16'h8000, 1'b0};
		endcase
	endfunction

	task automatic send_slot(input slot_t s, input logic typed, input wtm_res_t want,
			input int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.sample      <= s.smp;
		in_ch.active_mask <= s.mask;
		slot_typed        <= typed;
		slot_want         <= want;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (mix_expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic load_weights(input logic [TRACK_COUNT-1:0][VOL_W-1:0] w);
		int k;
		for (k = 0; k < TRACK_COUNT; k++) begin
			cfg_we   <= 1'b1;
			cfg_idx  <= CFG_IDX_W'(k);
			cfg_data <= w[k];
			@(posedge clk);
		end
		// index past the last track must be ignored
		cfg_idx  <= CFG_IDX_W'($urandom_range(TRACK_COUNT, (1 << CFG_IDX_W) - 1));
		cfg_data <= VOL_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		weight_sets++;
	endtask

	always @(posedge clk) begin : scoreboard
		wtm_res_t want;
		int       k;
		if (!arst_n) begin
			for (k = 0; k < TRACK_COUNT; k++)
				track_vol[k] <= VOL_RESET;
		end else begin
			if (cfg_we && cfg_idx < TRACK_COUNT)
				track_vol[cfg_idx[TRK_IDX_W-1:0]] <= cfg_data;
			if (in_ch.valid && in_ch.ready) begin
				slots_sent++;
				if (slot_typed)
					mix_expected_q.push_back(slot_want);
				else
					mix_expected_q.push_back(weighted_mix(in_ch.sample, in_ch.active_mask));
			end
			if (out_ch.valid && out_ch.ready) begin
				mixes_seen++;
				if (out_ch.no_weight)
					silent_mixes++;
				if (mix_expected_q.size() == 0) begin
					mix_errors++;
					$display("%0t unexpected mix: mixed %0d no_weight %0b", $time,
						out_ch.mixed_sample, out_ch.no_weight);
				end else begin
					want = mix_expected_q.pop_front();
					if (out_ch.mixed_sample !== want.mixed) begin
						mix_errors++;
						$display("%0t mixed_sample: expected %0d, got %0d", $time,
							want.mixed, out_ch.mixed_sample);
					end
					if (out_ch.no_weight !== want.no_weight) begin
						mix_errors++;
						$display("%0t no_weight: expected %0b, got %0b", $time,
							want.no_weight, out_ch.no_weight);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t timeout, %0d mixes outstanding", $time, mix_expected_q.size());
			$display("FAIL weighted_track_mixer_unit");
			$finish;
		end
	end

	initial begin : receiver
		int n;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (no_idle) begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				n = pick_gap();
				if (n > 0) begin
					out_ch.ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int                                i;
		int                                ph;
		int                                j;
		int                                k;
		dir_row_t                          row;
		slot_t                             s;
		logic [TRACK_COUNT-1:0][VOL_W-1:0] w;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = '0;
		cfg_data          = '0;
		in_ch.valid       = 1'b0;
		in_ch.sample      = '0;
		in_ch.active_mask = '0;
		slot_typed        = 1'b0;
		slot_want         = '0;
		hold_req          = 1'b0;
		no_idle           = 1'b0;
		weight_sets       = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++) begin
			if (i == DIR_REWEIGHT) begin
				wait_drained();
				load_weights({8'd0, 8'd1, 8'd255, 8'd0});
			end
			row = dir_row(i);
			send_slot(row.s, row.typed, row.want, pick_gap());
		end

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: w = {TRACK_COUNT{8'hFF}};
				1: w = '0;
				2: w = {8'd128, 8'd1, 8'd255, 8'd0};
				default: begin
					for (k = 0; k < TRACK_COUNT; k++)
						w[k] = ($urandom_range(0, 3) == 0) ? '0 : VOL_W'($urandom_range(1, 255));
				end
			endcase
			load_weights(w);
			no_idle = (ph == 3 || ph == 7);
			if (ph == 4) begin
				// long output stall with the input kept busy until it backs up
				hold_req = 1'b1;
				for (j = 0; j < BURST_SLOTS; j++) begin
					for (k = 0; k < TRACK_COUNT; k++)
						s.smp[k] = random_sample();
					s.mask = 4'($urandom_range(0, 15));
					send_slot(s, 1'b0, '0, 0);
				end
			end
			for (j = 0; j < PHASE_SLOTS; j++) begin
				if (j == 60 && ph % 3 == 1)
					wait_drained();
				for (k = 0; k < TRACK_COUNT; k++)
					s.smp[k] = random_sample();
				s.mask = 4'($urandom_range(0, 15));
				send_slot(s, 1'b0, '0, no_idle ? 0 : pick_gap());
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d slots over %0d weight settings, %0d mixes checked",
			slots_sent, weight_sets, mixes_seen);
		$display("%0d mixes had no active weight, %0d mismatches", silent_mixes, mix_errors);
		if (mix_errors == 0 && mix_expected_q.size() == 0)
			$display("PASS weighted_track_mixer_unit");
		else
			$display("FAIL weighted_track_mixer_unit");
		$finish;
	end

endmodule

### weighted_track_mixer_unit.f
hdl/wtm_pkg.sv
hdl/wtm_if.sv
hdl/wtm_lane.sv
hdl/wtm_merge.sv
hdl/wtm_div_step.sv
hdl/weighted_track_mixer_unit.sv
verif/weighted_track_mixer_unit_tb.sv
